### sv/rap_pkg.sv
// ----------------------------------------------------------------------------
// rap_pkg
// Shared types, constants and the elaboration-time ramp table generator
// for the rotator angle positioner.
// ----------------------------------------------------------------------------
`default_nettype none

package rap_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_CUR,
      ST_ERR,
      ST_DSETUP,
      ST_DIV,
      ST_LOOK,
      ST_MUL,
      ST_FIN
   } state_type;

   // configuration register indexes
   localparam logic [2:0] CSR_TARGET_ANGLE   = 3'd0;
   localparam logic [2:0] CSR_SENSOR_OFFSET  = 3'd1;
   localparam logic [2:0] CSR_STOP_TOLERANCE = 3'd2;
   localparam logic [2:0] CSR_MIN_DRIVE      = 3'd3;
   localparam logic [2:0] CSR_MAX_DRIVE      = 3'd4;
   localparam logic [2:0] CSR_RAMP_RANGE     = 3'd5;

   // register reset values
   localparam logic [15:0] RST_TARGET_ANGLE   = 16'd0;
   localparam logic [15:0] RST_SENSOR_OFFSET  = 16'd0;
   localparam logic [14:0] RST_STOP_TOLERANCE = 15'd30;
   localparam logic [7:0]  RST_MIN_DRIVE      = 8'd175;
   localparam logic [7:0]  RST_MAX_DRIVE      = 8'd255;
   localparam logic [14:0] RST_RAMP_RANGE     = 15'd1500;

   // angle constants, hundredths of a degree
   localparam logic [15:0]        FULL_TURN_U     = 16'd36000;
   localparam logic [15:0]        HALF_TURN_U     = 16'd18000;
   localparam logic signed [17:0] FULL_TURN_S     = 18'sd36000;
   localparam logic signed [17:0] HALF_TURN_S     = 18'sd18000;
   localparam logic signed [17:0] NEG_HALF_TURN_S = -18'sd18000;

   // drive saturation limits
   localparam logic signed [10:0] DRIVE_MAX_S = 11'sd255;
   localparam logic signed [10:0] DRIVE_MIN_S = -11'sd255;

   // pi/2 in Q30
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // sin^2 of a Q30 angle, Q0.16, taylor series to the 13th power
   function automatic logic [15:0] sin_sq_q16(input logic [63:0] theta);
      logic signed [63:0] sum;
      logic [63:0]        term;
      logic [63:0]        s;
      logic [63:0]        sq;
      sum  = $signed(theta);
      term = theta;
      for (int n = 1; n <= 6; n++) begin
         term = (term * theta) >> 30;
         term = (term * theta) >> 30;
         case (n)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            default: term = term / 64'd156;
         endcase
         if ((n & 1) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (sum > (64'sd1 <<< 30)) begin
         sum = 64'sd1 <<< 30;
      end
      s  = $unsigned(sum);
      sq = (s * s) >> 44;
      return (sq > 64'd65535) ? 16'hFFFF : sq[15:0];
   endfunction

endpackage

`default_nettype wire

### sv/rotator_angle_positioner.sv
// ----------------------------------------------------------------------------
// rotator_angle_positioner
// Corrects and mirrors an encoder angle, forms the wrapped target error and
// computes a sin-squared ramped, signed motor drive with a stop window.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_kind, req_sensor_angle
//   rsp      out        rsp_valid/stall    motor_drive, current_angle,
//                                          angle_error, done_res
//   csr      in         csr_wr_en          csr_index, csr_wr_data
//
// while a move is active a transaction runs the shared restoring divider twice,
// once for the distance to the target and once for the distance from the
// start, between ST_ERR and ST_FIN; idle samples go from ST_ERR straight to
// ST_FIN.
// req_stall is high while a transaction is in work; a finished result waits in
// the rsp register and the next transaction may be accepted meanwhile.
// synchronous reset loads the register defaults and clears the move.
//
`default_nettype none

module rotator_angle_positioner #(
   parameter int RAMP_TABLE_DEPTH = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic [15:0]        req_sensor_angle,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [8:0]       rsp_motor_drive,
   output logic [15:0]             rsp_current_angle,
   output logic signed [15:0]      rsp_angle_error,
   output logic                    rsp_done_res,
   // register write port
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_wr_data
);

   import rap_pkg::*;

   localparam int IDX_W = $clog2(RAMP_TABLE_DEPTH);
   localparam int NUM_W = 15 + IDX_W;
   localparam int CNT_W = $clog2(IDX_W);
   localparam logic [NUM_W-1:0] DEPTH_M1 = NUM_W'(RAMP_TABLE_DEPTH - 1);
   localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(RAMP_TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(IDX_W - 1);

   // ramp table, built at elaboration
   logic [15:0] ramp_rom [RAMP_TABLE_DEPTH];

   for (genvar k = 0; k < RAMP_TABLE_DEPTH; k++) begin : g_ramp
      localparam logic [63:0] THETA =
         (PI_HALF_Q30 * 64'(k)) / 64'(RAMP_TABLE_DEPTH - 1);
      assign ramp_rom[k] = sin_sq_q16(THETA);
   end

   // registers
   state_type               state_ff, state_in;
   logic [15:0]             target_ff, target_in;
   logic [15:0]             offset_ff, offset_in;
   logic [14:0]             tol_ff, tol_in;
   logic [7:0]              min_drv_ff, min_drv_in;
   logic [7:0]              max_drv_ff, max_drv_in;
   logic [14:0]             range_ff, range_in;
   logic [15:0]             start_ff, start_in;
   logic                    moving_ff, moving_in;
   logic                    kind_ff, kind_in;
   logic [15:0]             raw_ff, raw_in;
   logic [15:0]             v_ff, v_in;
   logic [15:0]             cur_ff, cur_in;
   logic signed [15:0]      err_ff, err_in;
   logic [14:0]             err_mag_ff, err_mag_in;
   logic [14:0]             sd_mag_ff, sd_mag_in;
   logic                    sel_ff, sel_in;
   logic [NUM_W-1:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]        dsh_ff, dsh_in;
   logic [IDX_W-1:0]        q_ff, q_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    far_ff, far_in;
   logic [15:0]             tab_q_ff, tab_q_in;
   logic signed [8:0]       acc_end_ff, acc_end_in;
   logic signed [8:0]       acc_start_ff, acc_start_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [8:0]       rsp_drive_ff, rsp_drive_in;
   logic [15:0]             rsp_cur_ff, rsp_cur_in;
   logic signed [15:0]      rsp_err_ff, rsp_err_in;
   logic                    rsp_done_ff, rsp_done_in;

   // corrected angle, reduced into one turn
   logic signed [17:0] ang_sum, ang_s1, ang_s2, ang_s3;
   assign ang_sum = $signed({2'b00, raw_ff}) + $signed({{2{offset_ff[15]}}, offset_ff});
   assign ang_s1  = ang_sum[17] ? ang_sum + FULL_TURN_S : ang_sum;
   assign ang_s2  = (ang_s1 >= FULL_TURN_S) ? ang_s1 - FULL_TURN_S : ang_s1;
   assign ang_s3  = (ang_s2 >= FULL_TURN_S) ? ang_s2 - FULL_TURN_S : ang_s2;

   // mirrored angle
   logic [15:0] cur_calc;
   assign cur_calc = (v_ff == 16'd0) ? 16'd0 : FULL_TURN_U - v_ff;

   // target error wrapped to half a turn
   logic signed [17:0] err_diff, err_e1, err_e2, err_e3, err_neg;
   assign err_diff = $signed({2'b00, target_ff}) - $signed({2'b00, cur_ff});
   assign err_e1   = (err_diff > HALF_TURN_S) ? err_diff - FULL_TURN_S : err_diff;
   assign err_e2   = (err_e1 > HALF_TURN_S) ? err_e1 - FULL_TURN_S : err_e1;
   assign err_e3   = (err_e2 < NEG_HALF_TURN_S) ? err_e2 + FULL_TURN_S : err_e2;
   assign err_neg  = -err_e3;

   // distance from the start angle
   logic signed [17:0] sd_diff, sd_w1, sd_w2, sd_neg;
   assign sd_diff = $signed({2'b00, cur_ff}) - $signed({2'b00, start_ff});
   assign sd_w1   = (sd_diff > HALF_TURN_S) ? sd_diff - FULL_TURN_S : sd_diff;
   assign sd_w2   = (sd_w1 < NEG_HALF_TURN_S) ? sd_w1 + FULL_TURN_S : sd_w1;
   assign sd_neg  = -sd_w2;

   // divider operands
   logic [14:0]      range_eff;
   logic [14:0]      dist_sel;
   logic [NUM_W-1:0] num_calc;
   assign range_eff = (range_ff == 15'd0) ? 15'd1 : range_ff;
   assign dist_sel  = sel_ff ? sd_mag_ff : err_mag_ff;
   assign num_calc  = NUM_W'(dist_sel) * DEPTH_M1 + NUM_W'(range_eff >> 1);

   // ramp scaling of the drive span
   logic signed [8:0] span;
   logic signed [8:0] span_neg;
   logic [7:0]        span_abs;
   logic [23:0]       prod;
   logic signed [8:0] accel;
   assign span     = $signed({1'b0, max_drv_ff}) - $signed({1'b0, min_drv_ff});
   assign span_neg = -span;
   assign span_abs = span[8] ? span_neg[7:0] : span[7:0];
   assign prod     = 24'(span_abs) * 24'(tab_q_ff);
   assign accel    = span[8] ? -$signed({1'b0, prod[23:16]}) : $signed({1'b0, prod[23:16]});

   // final speed, sign rule and stop window
   logic signed [8:0]  acc_min;
   logic signed [10:0] speed, speed_sgn, speed_sat;
   logic               pos_dir;
   logic               in_window;
   logic signed [16:0] err_ext, tol_ext;
   assign acc_min  = (acc_end_ff < acc_start_ff) ? acc_end_ff : acc_start_ff;
   assign speed    = $signed({{2{acc_min[8]}}, acc_min}) + $signed({3'b000, min_drv_ff});
   assign pos_dir  = ((err_ff > 16'sd0) &&
                      !((target_ff > HALF_TURN_U) && (start_ff < HALF_TURN_U))) ||
                     ((err_ff < 16'sd0) &&
                      (target_ff < HALF_TURN_U) && (start_ff > HALF_TURN_U));
   assign speed_sgn = pos_dir ? speed : -speed;
   assign speed_sat = (speed_sgn > DRIVE_MAX_S) ? DRIVE_MAX_S :
                      (speed_sgn < DRIVE_MIN_S) ? DRIVE_MIN_S : speed_sgn;
   assign err_ext   = 17'(err_ff);
   assign tol_ext   = $signed({2'b00, tol_ff});
   assign in_window = (err_ext <= tol_ext) && (err_ext >= -tol_ext);

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      offset_in    = offset_ff;
      tol_in       = tol_ff;
      min_drv_in   = min_drv_ff;
      max_drv_in   = max_drv_ff;
      range_in     = range_ff;
      start_in     = start_ff;
      moving_in    = moving_ff;
      kind_in      = kind_ff;
      raw_in       = raw_ff;
      v_in         = v_ff;
      cur_in       = cur_ff;
      err_in       = err_ff;
      err_mag_in   = err_mag_ff;
      sd_mag_in    = sd_mag_ff;
      sel_in       = sel_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      far_in       = far_ff;
      tab_q_in     = tab_q_ff;
      acc_end_in   = acc_end_ff;
      acc_start_in = acc_start_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // register writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_ANGLE:   target_in  = csr_wr_data;
            CSR_SENSOR_OFFSET:  offset_in  = csr_wr_data;
            CSR_STOP_TOLERANCE: tol_in     = csr_wr_data[14:0];
            CSR_MIN_DRIVE:      min_drv_in = csr_wr_data[7:0];
            CSR_MAX_DRIVE:      max_drv_in = csr_wr_data[7:0];
            CSR_RAMP_RANGE:     range_in   = csr_wr_data[14:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               raw_in   = req_sensor_angle;
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            v_in     = ang_s3[15:0];
            state_in = ST_CUR;
         end
         ST_CUR: begin
            cur_in = cur_calc;
            // start transaction latches the start angle
            if (!kind_ff) begin
               start_in  = cur_calc;
               moving_in = 1'b1;
            end
            state_in = ST_ERR;
         end
         ST_ERR: begin
            err_in     = err_e3[15:0];
            err_mag_in = err_e3[17] ? err_neg[14:0] : err_e3[14:0];
            sd_mag_in  = sd_w2[17] ? sd_neg[14:0] : sd_w2[14:0];
            sel_in     = 1'b0;
            state_in   = moving_ff ? ST_DSETUP : ST_FIN;
         end
         ST_DSETUP: begin
            rem_in   = num_calc;
            dsh_in   = NUM_W'(range_eff) << (IDX_W - 1);
            q_in     = '0;
            cnt_in   = CNT_INIT;
            far_in   = (dist_sel >= range_eff);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one restoring quotient bit per cycle
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = {q_ff[IDX_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[IDX_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = ST_LOOK;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_LOOK: begin
            tab_q_in = ramp_rom[far_ff ? IDX_MAX : q_ff];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (!sel_ff) begin
               acc_end_in = accel;
               sel_in     = 1'b1;
               state_in   = ST_DSETUP;
            end else begin
               acc_start_in = accel;
               state_in     = ST_FIN;
            end
         end
         ST_FIN: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_cur_in   = cur_ff;
               rsp_err_in   = err_ff;
               rsp_drive_in = 9'sd0;
               rsp_done_in  = 1'b0;
               if (moving_ff) begin
                  if (in_window) begin
                     rsp_done_in = 1'b1;
                     moving_in   = 1'b0;
                  end else begin
                     rsp_drive_in = speed_sat[8:0];
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= RST_TARGET_ANGLE;
         offset_ff    <= RST_SENSOR_OFFSET;
         tol_ff       <= RST_STOP_TOLERANCE;
         min_drv_ff   <= RST_MIN_DRIVE;
         max_drv_ff   <= RST_MAX_DRIVE;
         range_ff     <= RST_RAMP_RANGE;
         start_ff     <= 16'd0;
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         offset_ff    <= offset_in;
         tol_ff       <= tol_in;
         min_drv_ff   <= min_drv_in;
         max_drv_ff   <= max_drv_in;
         range_ff     <= range_in;
         start_ff     <= start_in;
         moving_ff    <= moving_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      raw_ff       <= raw_in;
      v_ff         <= v_in;
      cur_ff       <= cur_in;
      err_ff       <= err_in;
      err_mag_ff   <= err_mag_in;
      sd_mag_ff    <= sd_mag_in;
      sel_ff       <= sel_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      q_ff         <= q_in;
      cnt_ff       <= cnt_in;
      far_ff       <= far_in;
      tab_q_ff     <= tab_q_in;
      acc_end_ff   <= acc_end_in;
      acc_start_ff <= acc_start_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_cur_ff   <= rsp_cur_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_done_ff  <= rsp_done_in;
   end

   // outputs
   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_motor_drive   = rsp_drive_ff;
   assign rsp_current_angle = rsp_cur_ff;
   assign rsp_angle_error   = rsp_err_ff;
   assign rsp_done_res      = rsp_done_ff;

endmodule

`default_nettype wire

### dv/tb_rotator_angle_positioner.sv
// ----------------------------------------------------------------------------
// tb_rotator_angle_positioner
// Self-checking bench for the rotator angle positioner. A local model of the
// angle correction, target error, sin-squared ramp and stop window predicts
// every response; directed corner cases run first, then randomized moves
// under bursty request traffic and a varying response stall pattern.
// ----------------------------------------------------------------------------

module tb_rotator_angle_positioner;
   timeunit 1ns;
   timeprecision 1ps;

   import rap_pkg::*;

   localparam int   LUT_DEPTH       = 256;
   localparam int   WATCHDOG_LIMIT  = 2000;
   localparam int   END_HOLD_CYCLES = 40;
   localparam int   DEG_FULL        = 36000;
   localparam int   DEG_HALF        = 18000;
   localparam int   DRIVE_LIMIT     = 255;
   localparam logic KIND_START      = 1'b0;
   localparam logic KIND_SAMPLE     = 1'b1;

   typedef struct {
      logic [15:0]        target;
      logic signed [15:0] offset;
      logic [14:0]        tolerance;
      logic [7:0]         drive_lo;
      logic [7:0]         drive_hi;
      logic [14:0]        ramp_len;
   } positioner_cfg_type;

   typedef struct {
      logic signed [8:0]  drive;
      logic [15:0]        angle;
      logic signed [15:0] error;
      logic               done;
   } drive_result_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic               req_kind         = 1'b0;
   logic [15:0]        req_sensor_angle = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic signed [8:0]  rsp_motor_drive;
   logic [15:0]        rsp_current_angle;
   logic signed [15:0] rsp_angle_error;
   logic               rsp_done_res;
   logic               csr_wr_en        = 1'b0;
   logic [2:0]         csr_index        = '0;
   logic [15:0]        csr_wr_data      = '0;

   // model state
   positioner_cfg_type shadow_cfg;
   int                 move_start;
   logic               move_active;
   logic [15:0]        ramp_lut [LUT_DEPTH];
   drive_result_type   expected_q [$];

   int             error_count  = 0;
   int             quiet_cycles = 0;
   int             burst_left   = 0;
   stall_mode_type stall_mode   = STALL_NONE;
   int             stall_span   = 0;
   int             stall_tick   = 0;
   int             stall_period = 4;

   rotator_angle_positioner #(
      .RAMP_TABLE_DEPTH(LUT_DEPTH)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_sensor_angle  (req_sensor_angle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_motor_drive   (rsp_motor_drive),
      .rsp_current_angle (rsp_current_angle),
      .rsp_angle_error   (rsp_angle_error),
      .rsp_done_res      (rsp_done_res),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // sin^2 of a q30 angle in q0.16, taylor series through the 13th power
   function automatic logic [15:0] sinsq_q16(input logic [63:0] ang);
      logic signed [63:0] acc;
      logic [63:0]        pw;
      logic [63:0]        mag;
      logic [63:0]        sq;
      acc = $signed(ang);
      pw  = ang;
      for (int n = 1; n <= 6; n++) begin
         pw = (pw * ang) >> 30;
         pw = (pw * ang) >> 30;
         pw = pw / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            acc = acc - $signed(pw);
         end else begin
            acc = acc + $signed(pw);
         end
      end
      if (acc < 0) begin
         acc = 64'sd0;
      end
      if (acc > (64'sd1 <<< 30)) begin
         acc = 64'sd1 <<< 30;
      end
      mag = $unsigned(acc);
      sq  = (mag * mag) >> 44;
      return (sq > 64'd65535) ? 16'hFFFF : sq[15:0];
   endfunction

   function automatic int wrap_half_turn(input int e);
      while (e > DEG_HALF) e -= DEG_FULL;
      while (e < -DEG_HALF) e += DEG_FULL;
      return e;
   endfunction

   // ramp contribution for one distance, sign follows max_drive - min_drive
   function automatic int ramp_gain(input int span_len);
      int rng;
      int d;
      int idx;
      int diff;
      int mag;
      rng  = (shadow_cfg.ramp_len != 0) ? int'(shadow_cfg.ramp_len) : 1;
      d    = (span_len < 0) ? -span_len : span_len;
      diff = int'(shadow_cfg.drive_hi) - int'(shadow_cfg.drive_lo);
      if (d >= rng) begin
         idx = LUT_DEPTH - 1;
      end else begin
         idx = (d * (LUT_DEPTH - 1) + rng / 2) / rng;
      end
      if (idx > LUT_DEPTH - 1) begin
         idx = LUT_DEPTH - 1;
      end
      mag = (((diff < 0) ? -diff : diff) * int'(ramp_lut[idx])) >>> 16;
      return (diff < 0) ? -mag : mag;
   endfunction

   // expected response for one accepted request, advances the move state
   function automatic drive_result_type predict_drive(input logic kind,
                                                      input logic [15:0] raw_angle);
      int               raw;
      int               off;
      int               v;
      int               cur;
      int               err;
      int               a_end;
      int               a_start;
      int               speed;
      int               tol;
      logic             tgt_hi;
      logic             tgt_lo;
      logic             st_hi;
      logic             st_lo;
      logic             positive;
      drive_result_type res;
      raw = int'(raw_angle);
      off = int'(shadow_cfg.offset);
      v   = (raw + off) % DEG_FULL;
      if (v < 0) begin
         v += DEG_FULL;
      end
      cur = (DEG_FULL - v) % DEG_FULL;
      err = wrap_half_turn(int'(shadow_cfg.target) - cur);
      tol = int'(shadow_cfg.tolerance);
      res.drive = '0;
      res.done  = 1'b0;
      if (kind == KIND_START) begin
         move_start  = cur;
         move_active = 1'b1;
      end
      if (move_active) begin
         a_end    = ramp_gain(err);
         a_start  = ramp_gain(wrap_half_turn(cur - move_start));
         speed    = ((a_end < a_start) ? a_end : a_start) + int'(shadow_cfg.drive_lo);
         tgt_hi   = int'(shadow_cfg.target) > DEG_HALF;
         tgt_lo   = int'(shadow_cfg.target) < DEG_HALF;
         st_hi    = move_start > DEG_HALF;
         st_lo    = move_start < DEG_HALF;
         positive = (err > 0 && !(tgt_hi && st_lo)) || (err < 0 && tgt_lo && st_hi);
         if (!positive) begin
            speed = -speed;
         end
         if (speed > DRIVE_LIMIT) begin
            speed = DRIVE_LIMIT;
         end
         if (speed < -DRIVE_LIMIT) begin
            speed = -DRIVE_LIMIT;
         end
         if (err > tol || err < -tol) begin
            res.drive = 9'(speed);
         end else begin
            res.done    = 1'b1;
            move_active = 1'b0;
         end
      end
      res.angle = 16'(cur);
      res.error = 16'(err);
      return res;
   endfunction

   // raw sensor reading that maps to a wanted corrected angle
   function automatic logic [15:0] sensor_for_angle(input int c);
      int v;
      int raw;
      v   = (DEG_FULL - c) % DEG_FULL;
      raw = (v - int'(shadow_cfg.offset)) % DEG_FULL;
      if (raw < 0) begin
         raw += DEG_FULL;
      end
      // sometimes an equivalent reading beyond one turn
      if ($urandom_range(0, 7) == 0 && raw + DEG_FULL <= 65535) begin
         raw += DEG_FULL;
      end
      return 16'(raw);
   endfunction

   function automatic int pick_edge_biased(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return lo;
      if (r == 1) return hi;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // one request transaction, then at the end of a burst a random gap
   task automatic send_item(input logic kind, input logic [15:0] angle);
      int gap;
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_sensor_angle <= angle;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      expected_q.push_back(predict_drive(kind, angle));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid        <= 1'b0;
            req_kind         <= 1'($urandom);
            req_sensor_angle <= 16'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // program all registers, unused upper data bits carry junk
   task automatic apply_settings(input positioner_cfg_type c);
      csr_write(CSR_TARGET_ANGLE, c.target);
      csr_write(CSR_SENSOR_OFFSET, c.offset);
      csr_write(CSR_STOP_TOLERANCE, {1'($urandom), c.tolerance});
      csr_write(CSR_MIN_DRIVE, {8'($urandom), c.drive_lo});
      csr_write(CSR_MAX_DRIVE, {8'($urandom), c.drive_hi});
      csr_write(CSR_RAMP_RANGE, {1'($urandom), c.ramp_len});
      csr_wr_en  <= 1'b0;
      shadow_cfg = c;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // idle samples, a start and a stop under reset defaults
   task automatic test_reset_defaults();
      send_item(KIND_SAMPLE, 16'd0);
      send_item(KIND_SAMPLE, 16'd35999);
      send_item(KIND_START, 16'd9000);
      send_item(KIND_SAMPLE, 16'd4000);
      send_item(KIND_SAMPLE, 16'd0);
      drain_results();
   endtask

   // field and register extremes, zero ramp range, max below min
   task automatic test_field_extremes();
      apply_settings('{16'd35999, -16'sd18000, 15'd0, 8'd0, 8'd255, 15'd1});
      send_item(KIND_START, 16'hFFFF);
      send_item(KIND_SAMPLE, 16'h8000);
      send_item(KIND_SAMPLE, 16'd35999);
      send_item(KIND_SAMPLE, 16'd0);
      send_item(KIND_SAMPLE, 16'd18000);
      drain_results();
      apply_settings('{16'hFFFF, 16'sh7FFF, 15'h7FFF, 8'd255, 8'd0, 15'd0});
      send_item(KIND_START, 16'd0);
      send_item(KIND_SAMPLE, 16'hFFFF);
      drain_results();
   endtask

   // restart while moving and each side of the direction rule
   task automatic test_restart_and_sign();
      apply_settings('{16'd18000, 16'sh8000, 15'd0, 8'd255, 8'd255, 15'h7FFF});
      send_item(KIND_START, 16'd1234);
      send_item(KIND_SAMPLE, 16'd12345);
      send_item(KIND_START, 16'd20000);
      send_item(KIND_SAMPLE, 16'd17000);
      drain_results();
      // target above half turn, start above it as well
      apply_settings('{16'd18001, 16'sd18000, 15'd18000, 8'd200, 8'd10, 15'd18000});
      send_item(KIND_START, 16'd30000);
      send_item(KIND_SAMPLE, 16'd5000);
      send_item(KIND_SAMPLE, 16'd25000);
      drain_results();
      // target below half turn, start above
      apply_settings('{16'd100, 16'sd0, 15'd10, 8'd60, 8'd240, 15'd500});
      send_item(KIND_START, 16'd10000);
      send_item(KIND_SAMPLE, 16'd35000);
      send_item(KIND_SAMPLE, 16'd35900);
      drain_results();
   endtask

   // random settings, mostly well formed approaches toward the target
   task automatic test_random_moves();
      positioner_cfg_type rc;
      int                 sent;
      int                 c;
      int                 e;
      int                 step;
      int                 delta;
      int                 n;
      int                 r;
      for (int phase = 0; phase < 24; phase++) begin
         rc.target = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                 : 16'(pick_edge_biased(0, 35999));
         rc.offset = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                 : 16'(pick_edge_biased(-18000, 18000));
         case ($urandom_range(0, 9))
            0:       rc.tolerance = 15'($urandom);
            1, 2:    rc.tolerance = 15'(pick_edge_biased(0, 18000));
            default: rc.tolerance = 15'($urandom_range(0, 300));
         endcase
         rc.drive_lo = 8'(pick_edge_biased(0, 255));
         rc.drive_hi = 8'(pick_edge_biased(0, 255));
         case ($urandom_range(0, 11))
            0:       rc.ramp_len = 15'd0;
            1:       rc.ramp_len = 15'($urandom);
            default: rc.ramp_len = 15'(pick_edge_biased(1, 18000));
         endcase
         apply_settings(rc);
         sent = 0;
         while (sent < 52) begin
            r = $urandom_range(0, 9);
            if (r < 8) begin
               // start, step toward the target until the stop window
               c = $urandom_range(0, DEG_FULL - 1);
               send_item(KIND_START, sensor_for_angle(c));
               sent++;
               n    = 0;
               step = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 300)
                                                  : $urandom_range(300, 6000);
               while (move_active && n < 40 && sent < 52) begin
                  e     = wrap_half_turn(int'(shadow_cfg.target) - c);
                  delta = (e > step) ? step : ((e < -step) ? -step : e);
                  if ($urandom_range(0, 5) == 0) begin
                     delta += int'($urandom_range(0, 400)) - 200;
                  end
                  c = ((c + delta) % DEG_FULL + DEG_FULL) % DEG_FULL;
                  send_item(KIND_SAMPLE, sensor_for_angle(c));
                  sent++;
                  n++;
               end
               repeat ($urandom_range(0, 2)) begin
                  send_item(KIND_SAMPLE, sensor_for_angle(c));
                  sent++;
               end
            end else if (r == 8) begin
               // noise on both fields
               repeat ($urandom_range(1, 4)) begin
                  send_item(1'($urandom), 16'($urandom));
                  sent++;
               end
            end else begin
               // broken move: jumps, then a restart mid move
               send_item(KIND_START, 16'($urandom));
               repeat ($urandom_range(1, 4)) begin
                  send_item(KIND_SAMPLE, sensor_for_angle($urandom_range(0, DEG_FULL - 1)));
                  sent++;
               end
               send_item(KIND_START, sensor_for_angle($urandom_range(0, DEG_FULL - 1)));
               sent += 2;
            end
         end
         drain_results();
      end
   endtask

   // response stall pattern, mode changes when a random span runs out
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode   <= stall_mode_type'($urandom_range(0, 3));
         stall_span   <= $urandom_range(20, 300);
         stall_period <= $urandom_range(2, 16);
      end else begin
         stall_span <= stall_span - 1;
      end
      stall_tick <= stall_tick + 1;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_tick % stall_period) < (stall_period / 2);
      endcase
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin : result_check
      drive_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_q.size() == 0) begin
            error_count++;
            $display("%0t unexpected response: drive %0d angle %0d error %0d done %0b",
                     $time, rsp_motor_drive, rsp_current_angle, rsp_angle_error,
                     rsp_done_res);
         end else begin
            want = expected_q.pop_front();
            if (rsp_motor_drive !== want.drive) begin
               error_count++;
               $display("%0t motor_drive mismatch: expected %0d actual %0d",
                        $time, want.drive, rsp_motor_drive);
            end
            if (rsp_current_angle !== want.angle) begin
               error_count++;
               $display("%0t current_angle mismatch: expected %0d actual %0d",
                        $time, want.angle, rsp_current_angle);
            end
            if (rsp_angle_error !== want.error) begin
               error_count++;
               $display("%0t angle_error mismatch: expected %0d actual %0d",
                        $time, want.error, rsp_angle_error);
            end
            if (rsp_done_res !== want.done) begin
               error_count++;
               $display("%0t done_res mismatch: expected %0b actual %0b",
                        $time, want.done, rsp_done_res);
            end
         end
      end
   end

   // count cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL rotator_angle_positioner");
      $finish;
   end

   initial begin
      shadow_cfg = '{RST_TARGET_ANGLE, RST_SENSOR_OFFSET, RST_STOP_TOLERANCE,
                     RST_MIN_DRIVE, RST_MAX_DRIVE, RST_RAMP_RANGE};
      move_start  = 0;
      move_active = 1'b0;
      for (int k = 0; k < LUT_DEPTH; k++) begin
         ramp_lut[k] = sinsq_q16((PI_HALF_Q30 * 64'(k)) / 64'(LUT_DEPTH - 1));
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_restart_and_sign();
      test_random_moves();
      drain_results();
      repeat (END_HOLD_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("PASS rotator_angle_positioner");
      end else begin
         if (expected_q.size() != 0) begin
            $display("%0t %0d responses never arrived", $time, expected_q.size());
         end
         $display("FAIL rotator_angle_positioner");
      end
      $finish;
   end

endmodule
